// ----- design/wfau_pkg.sv -----
// Shared types and constants for the wide float arithmetic unit.
// Depends on nothing; every other design file imports it.
`default_nettype none

package wfau_pkg;

  localparam int EXP_W     = 40;
  localparam int IO_EXP_W  = 32;
  localparam int IO_MANT_W = 64;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4,
    OP_NEG = 3'd5,
    OP_ABS = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIVZ = 2'd1,
    ST_OVF  = 2'd2
  } status_e;

  localparam logic [1:0] ORD_LT = 2'b11;
  localparam logic [1:0] ORD_EQ = 2'b00;
  localparam logic [1:0] ORD_GT = 2'b01;

  typedef struct packed {
    logic       sign;
    status_e    status;
    logic [1:0] order;
  } meta_t;

endpackage

`default_nettype wire

// ----- design/wide_float_arith_unit_top.sv -----
// Top level of the wide float arithmetic unit: unpack, align/multiply/compare,
// add and product sum, delay to the divider, renormalize.
// Depends on wfau_pkg, wfau_unpack, wfau_div, wfau_norm.
//
//   channel  | handshake              | beat
//   ---------+------------------------+------------------------------------------
//   in       | in_valid_i / in_ready_o| operation, a_sign/exp/mant, b_sign/exp/mant
//   out      | out_valid_o/out_ready_i| r_sign, r_exp, r_mant, order, status
//
// One beat enters per cycle while no output beat waits; each result passes the input,
// align and core registers, a delay matched to the two-bit-per-stage divider, and the renormalizer.
// The whole pipeline holds while an output beat waits; ready drops then.
// Reset clears valid bits only; no other state is kept between beats.
`default_nettype none

module wide_float_arith_unit_top #(
  parameter int MANT_BITS = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [2:0]                             operation_i,
  input  logic                                   a_sign_i,
  input  logic signed [wfau_pkg::IO_EXP_W-1:0]   a_exp_i,
  input  logic        [wfau_pkg::IO_MANT_W-1:0]  a_mant_i,
  input  logic                                   b_sign_i,
  input  logic signed [wfau_pkg::IO_EXP_W-1:0]   b_exp_i,
  input  logic        [wfau_pkg::IO_MANT_W-1:0]  b_mant_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   r_sign_o,
  output logic signed [wfau_pkg::IO_EXP_W-1:0]   r_exp_o,
  output logic        [wfau_pkg::IO_MANT_W-1:0]  r_mant_o,
  output logic signed [1:0]                      order_o,
  output wfau_pkg::status_e                      status_o
);
  import wfau_pkg::*;

  localparam int M     = MANT_BITS;
  localparam int W     = 2 * M;
  localparam int H     = (M + 1) / 2;
  localparam int HW    = M - H;
  localparam int NS    = (M + 1) / 2;
  localparam int SW    = $clog2(M + 2);
  localparam int PLL_W = 2 * H;
  localparam int PLH_W = H + HW;
  localparam int PHH_W = 2 * HW;

  typedef struct packed {
    logic                    sign;
    logic signed [EXP_W-1:0] exp;
    logic [M-1:0]            mant;
    logic                    zero;
  } num_t;

  typedef struct packed {
    logic                    sign;
    logic signed [EXP_W-1:0] exp;
    logic [W-1:0]            val;
    logic                    use_div;
    status_e                 status;
    logic [1:0]              order;
  } core_t;

  logic en;
  num_t a_d, b_d, a1_q, b1_q;
  op_e  op1_q, op2_q;
  logic v1_q, v2_q, v3_q;
  logic vd_q [NS];

  num_t                    bx, lo, ro, a2_q, b2_q, l2_q;
  logic signed [EXP_W-1:0] diff;
  logic [SW-1:0]           sh;
  logic [2*M:0]            ext;
  logic                    rsign2_q, rg2_q, rst2_q;
  logic [M-1:0]            rq2_q;
  logic [PLL_W-1:0]        pll2_q;
  logic [PLH_W-1:0]        plh2_q, phl2_q;
  logic [PHH_W-1:0]        phh2_q;
  logic [1:0]              ord_d, ord2_q;

  core_t        core_d, core3_q, last;
  core_t        dly_q [NS];
  logic [M+1:0] div_quo;
  meta_t        meta;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  wfau_unpack #(.MANT_BITS(M)) u_unpack_a (
    .sign_i (a_sign_i),
    .exp_i  (a_exp_i),
    .mant_i (a_mant_i),
    .sign_o (a_d.sign),
    .exp_o  (a_d.exp),
    .mant_o (a_d.mant),
    .zero_o (a_d.zero)
  );

  wfau_unpack #(.MANT_BITS(M)) u_unpack_b (
    .sign_i (b_sign_i),
    .exp_i  (b_exp_i),
    .mant_i (b_mant_i),
    .sign_o (b_d.sign),
    .exp_o  (b_d.exp),
    .mant_o (b_d.mant),
    .zero_o (b_d.zero)
  );

  // align the smaller operand, keep guard and sticky for rounding, and order a against b
  always_comb begin
    logic lt;
    bx      = b1_q;
    bx.sign = b1_q.sign ^ (op1_q == OP_SUB);
    if (a1_q.exp < b1_q.exp) begin
      lo = bx;
      ro = a1_q;
    end else begin
      lo = a1_q;
      ro = bx;
    end
    diff = lo.exp - ro.exp;
    sh   = (diff > EXP_W'(M + 1)) ? SW'(M + 1) : diff[SW-1:0];
    ext  = {ro.mant, {(M + 1){1'b0}}} >> sh;

    if (a1_q.exp != b1_q.exp) lt = a1_q.exp < b1_q.exp;
    else                      lt = a1_q.mant < b1_q.mant;
    if (a1_q.zero && b1_q.zero)          ord_d = ORD_EQ;
    else if (a1_q.zero)                  ord_d = b1_q.sign ? ORD_GT : ORD_LT;
    else if (b1_q.zero)                  ord_d = a1_q.sign ? ORD_LT : ORD_GT;
    else if (a1_q.sign != b1_q.sign)     ord_d = a1_q.sign ? ORD_LT : ORD_GT;
    else if ((a1_q.exp == b1_q.exp) && (a1_q.mant == b1_q.mant)) ord_d = ORD_EQ;
    else if (lt ^ a1_q.sign)             ord_d = ORD_LT;
    else                                 ord_d = ORD_GT;
  end

  wfau_div #(.MANT_BITS(M)) u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (a1_q.mant),
    .den_i (b1_q.mant),
    .quo_o (div_quo)
  );

  always_comb begin
    logic         inc;
    logic [M:0]   rs, lm;
    logic [W-1:0] prod;
    inc  = rg2_q & (rst2_q | rq2_q[0]);
    rs   = {1'b0, rq2_q} + (M + 1)'(inc);
    lm   = {1'b0, l2_q.mant};
    prod = W'(pll2_q) + (W'(plh2_q) << H) + (W'(phl2_q) << H) + (W'(phh2_q) << (2 * H));

    core_d = '{sign: 1'b0, exp: '0, val: '0, use_div: 1'b0,
               status: ST_OK, order: ORD_EQ};
    case (op2_q)
      OP_ADD, OP_SUB: begin
        if (a2_q.zero) begin
          core_d.val  = W'(b2_q.mant);
          core_d.sign = b2_q.sign;
          core_d.exp  = b2_q.exp;
        end else if (b2_q.zero) begin
          core_d.val  = W'(a2_q.mant);
          core_d.sign = a2_q.sign;
          core_d.exp  = a2_q.exp;
        end else begin
          core_d.exp = l2_q.exp;
          if (l2_q.sign == rsign2_q) begin
            core_d.val  = W'(lm + rs);
            core_d.sign = l2_q.sign;
          end else if (lm > rs) begin
            core_d.val  = W'(lm - rs);
            core_d.sign = l2_q.sign;
          end else if (lm < rs) begin
            core_d.val  = W'(rs - lm);
            core_d.sign = rsign2_q;
          end
        end
      end
      OP_MUL: begin
        if (!a2_q.zero && !b2_q.zero) begin
          core_d.val  = prod;
          core_d.sign = a2_q.sign ^ b2_q.sign;
          core_d.exp  = a2_q.exp + b2_q.exp;
        end
      end
      OP_DIV: begin
        if (b2_q.zero) begin
          core_d.status = ST_DIVZ;
        end else begin
          core_d.use_div = !a2_q.zero;
          core_d.sign    = a2_q.sign ^ b2_q.sign;
          core_d.exp     = a2_q.exp - b2_q.exp - EXP_W'(M);
        end
      end
      OP_CMP: core_d.order = ord2_q;
      OP_NEG: begin
        core_d.val  = W'(a2_q.mant);
        core_d.sign = !a2_q.sign;
        core_d.exp  = a2_q.exp;
      end
      OP_ABS: begin
        core_d.val = W'(a2_q.mant);
        core_d.exp = a2_q.exp;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      for (int i = 0; i < NS; i++) vd_q[i] <= 1'b0;
    end else if (en) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      vd_q[0] <= v3_q;
      for (int i = 1; i < NS; i++) vd_q[i] <= vd_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q     <= a_d;
      b1_q     <= b_d;
      op1_q    <= op_e'(operation_i);
      op2_q    <= op1_q;
      a2_q     <= a1_q;
      b2_q     <= bx;
      l2_q     <= lo;
      rsign2_q <= ro.sign;
      rq2_q    <= ext[2*M:M+1];
      rg2_q    <= ext[M];
      rst2_q   <= |ext[M-1:0];
      pll2_q   <= PLL_W'(a1_q.mant[H-1:0]) * PLL_W'(b1_q.mant[H-1:0]);
      plh2_q   <= PLH_W'(a1_q.mant[H-1:0]) * PLH_W'(b1_q.mant[M-1:H]);
      phl2_q   <= PLH_W'(a1_q.mant[M-1:H]) * PLH_W'(b1_q.mant[H-1:0]);
      phh2_q   <= PHH_W'(a1_q.mant[M-1:H]) * PHH_W'(b1_q.mant[M-1:H]);
      ord2_q   <= ord_d;
      core3_q  <= core_d;
      dly_q[0] <= core3_q;
      for (int i = 1; i < NS; i++) dly_q[i] <= dly_q[i-1];
    end
  end

  assign last = dly_q[NS-1];
  assign meta = '{sign: last.sign, status: last.status, order: last.order};

  wfau_norm #(.MANT_BITS(M)) u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (vd_q[NS-1]),
    .meta_i   (meta),
    .exp_i    (last.exp),
    .val_i    (last.use_div ? W'(div_quo) : last.val),
    .valid_o  (out_valid_o),
    .r_sign_o (r_sign_o),
    .r_exp_o  (r_exp_o),
    .r_mant_o (r_mant_o),
    .order_o  (order_o),
    .status_o (status_o)
  );

endmodule

`default_nettype wire

// ----- design/wfau_unpack.sv -----
// Operand unpack: mask the mantissa, count leading zeros and left-justify it.
// Depends on wfau_pkg.
`default_nettype none

module wfau_unpack #(
  parameter int MANT_BITS = 64
) (
  input  logic                                    sign_i,
  input  logic signed [wfau_pkg::IO_EXP_W-1:0]    exp_i,
  input  logic        [wfau_pkg::IO_MANT_W-1:0]   mant_i,
  output logic                                    sign_o,
  output logic signed [wfau_pkg::EXP_W-1:0]       exp_o,
  output logic        [MANT_BITS-1:0]             mant_o,
  output logic                                    zero_o
);
  import wfau_pkg::*;

  localparam int LZW = $clog2(MANT_BITS + 1);

  logic [MANT_BITS-1:0] m;
  logic [LZW-1:0]       lz;

  always_comb begin
    m  = mant_i[MANT_BITS-1:0];
    lz = LZW'(MANT_BITS);
    for (int i = 0; i < MANT_BITS; i++) begin
      if (m[i]) lz = LZW'(MANT_BITS - 1 - i);
    end
  end

  assign sign_o = sign_i;
  assign mant_o = m << lz;
  assign exp_o  = EXP_W'(exp_i) - EXP_W'(lz);
  assign zero_o = (m == '0);

endmodule

`default_nettype wire

// ----- design/wfau_div.sv -----
// Pipelined restoring divider: (num << MANT_BITS) / den, one quotient bit in the first
// stage and up to two per later stage, then a round-half-even stage. Depends on wfau_pkg.
`default_nettype none

module wfau_div #(
  parameter int MANT_BITS = 64
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [MANT_BITS-1:0]   num_i,
  input  logic [MANT_BITS-1:0]   den_i,
  output logic [MANT_BITS+1:0]   quo_o
);
  import wfau_pkg::*;

  localparam int NS = (MANT_BITS + 1) / 2;
  localparam int QW = MANT_BITS + 1;

  logic [MANT_BITS-1:0] rem_q [NS+1];
  logic [MANT_BITS-1:0] rem_d [NS+1];
  logic [QW-1:0]        quo_q [NS+1];
  logic [QW-1:0]        quo_d [NS+1];
  logic [MANT_BITS-1:0] den_q [NS+1];
  logic [MANT_BITS+1:0] res_q;
  logic [MANT_BITS+1:0] res_d;

  always_comb begin
    if (num_i >= den_i) begin
      rem_d[0] = num_i - den_i;
      quo_d[0] = QW'(1);
    end else begin
      rem_d[0] = num_i;
      quo_d[0] = '0;
    end
  end

  for (genvar j = 1; j <= NS; j++) begin : g_stage
    always_comb begin
      logic [MANT_BITS:0]   r2;
      logic [MANT_BITS-1:0] r;
      logic [QW-1:0]        q;
      r2 = '0;
      r  = rem_q[j-1];
      q  = quo_q[j-1];
      for (int k = 0; k < 2; k++) begin
        if (2 * (j - 1) + k < MANT_BITS) begin
          r2 = {r, 1'b0};
          if (r2 >= {1'b0, den_q[j-1]}) begin
            r2 = r2 - {1'b0, den_q[j-1]};
            q  = {q[QW-2:0], 1'b1};
          end else begin
            q  = {q[QW-2:0], 1'b0};
          end
          r = r2[MANT_BITS-1:0];
        end
      end
      rem_d[j] = r;
      quo_d[j] = q;
    end
  end

  always_comb begin
    logic [MANT_BITS:0] r2;
    logic               up;
    r2    = {rem_q[NS], 1'b0};
    up    = (r2 > {1'b0, den_q[NS]}) ||
            ((r2 == {1'b0, den_q[NS]}) && quo_q[NS][0]);
    res_d = {1'b0, quo_q[NS]} + (MANT_BITS + 2)'(up);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j <= NS; j++) begin
        rem_q[j] <= rem_d[j];
        quo_q[j] <= quo_d[j];
        den_q[j] <= (j == 0) ? den_i : den_q[(j == 0) ? 0 : j - 1];
      end
      res_q <= res_d;
    end
  end

  assign quo_o = res_q;

endmodule

`default_nettype wire

// ----- design/wfau_norm.sv -----
// Three-stage renormalizer: bit length, shift with guard/sticky, then
// round-half-even, carry fix, range check and the output register.
// Depends on wfau_pkg.
`default_nettype none

module wfau_norm #(
  parameter int MANT_BITS = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  wfau_pkg::meta_t                       meta_i,
  input  logic signed [wfau_pkg::EXP_W-1:0]     exp_i,
  input  logic        [2*MANT_BITS-1:0]         val_i,
  output logic                                  valid_o,
  output logic                                  r_sign_o,
  output logic        [wfau_pkg::IO_EXP_W-1:0]  r_exp_o,
  output logic        [wfau_pkg::IO_MANT_W-1:0] r_mant_o,
  output logic        [1:0]                     order_o,
  output wfau_pkg::status_e                     status_o
);
  import wfau_pkg::*;

  localparam int W   = 2 * MANT_BITS;
  localparam int BLW = $clog2(W + 1);
  localparam logic signed [EXP_W-1:0] EMAX = EXP_W'(2147483647);
  localparam logic signed [EXP_W-1:0] EMIN = -EMAX - EXP_W'(1);

  logic                    v1_q, v2_q, v3_q;
  meta_t                   m1_q, m2_q;
  logic signed [EXP_W-1:0] e1_q, e2_q, e2_d, ef;
  logic [W-1:0]            val1_q;
  logic [BLW-1:0]          bl_d, bl1_q;
  logic [MANT_BITS-1:0]    mt2_q, mt2_d, mf;
  logic                    g2_q, g2_d, s2_q, s2_d, z2_q;
  logic                    sign3_q;
  logic [IO_EXP_W-1:0]     exp3_q;
  logic [MANT_BITS-1:0]    mant3_q;
  logic [1:0]              ord3_q;
  status_e                 st3_q;
  logic                    ovf;

  always_comb begin
    bl_d = '0;
    for (int i = 0; i < W; i++) begin
      if (val_i[i]) bl_d = BLW'(i + 1);
    end
  end

  always_comb begin
    logic [2*W-1:0] ext;
    logic [BLW-1:0] sr;
    ext = '0;
    sr  = '0;
    if (bl1_q > BLW'(MANT_BITS)) begin
      sr    = bl1_q - BLW'(MANT_BITS);
      ext   = {val1_q, {W{1'b0}}} >> sr;
      mt2_d = ext[W+MANT_BITS-1:W];
      g2_d  = ext[W-1];
      s2_d  = |ext[W-2:0];
    end else begin
      mt2_d = val1_q[MANT_BITS-1:0] << (BLW'(MANT_BITS) - bl1_q);
      g2_d  = 1'b0;
      s2_d  = 1'b0;
    end
    e2_d = e1_q + EXP_W'(bl1_q) - EXP_W'(MANT_BITS);
  end

  always_comb begin
    logic               inc;
    logic [MANT_BITS:0] sum;
    inc = g2_q & (s2_q | mt2_q[0]);
    sum = {1'b0, mt2_q} + (MANT_BITS + 1)'(inc);
    if (sum[MANT_BITS]) begin
      mf = {1'b1, {(MANT_BITS - 1){1'b0}}};
      ef = e2_q + EXP_W'(1);
    end else begin
      mf = sum[MANT_BITS-1:0];
      ef = e2_q;
    end
    ovf = !z2_q && ((ef > EMAX) || (ef < EMIN));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q   <= meta_i;
      e1_q   <= exp_i;
      val1_q <= val_i;
      bl1_q  <= bl_d;
      m2_q   <= m1_q;
      e2_q   <= e2_d;
      mt2_q  <= mt2_d;
      g2_q   <= g2_d;
      s2_q   <= s2_d;
      z2_q   <= (bl1_q == '0);
      ord3_q <= m2_q.order;
      if (z2_q || ovf) begin
        sign3_q <= 1'b0;
        exp3_q  <= '0;
        mant3_q <= '0;
        st3_q   <= ovf ? ST_OVF : m2_q.status;
      end else begin
        sign3_q <= m2_q.sign;
        exp3_q  <= ef[IO_EXP_W-1:0];
        mant3_q <= mf;
        st3_q   <= m2_q.status;
      end
    end
  end

  assign valid_o  = v3_q;
  assign r_sign_o = sign3_q;
  assign r_exp_o  = exp3_q;
  assign r_mant_o = IO_MANT_W'(mant3_q);
  assign order_o  = ord3_q;
  assign status_o = st3_q;

endmodule

`default_nettype wire

// ----- design/wfau_checker.sv -----
// Port-level checks for the wide float arithmetic unit, bound to the top level.
// Depends on wfau_pkg and wide_float_arith_unit_top.
`default_nettype none

module wfau_checker #(
  parameter int MANT_BITS = 64
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_ready_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic                                 r_sign_i,
  input logic        [wfau_pkg::IO_EXP_W-1:0] r_exp_i,
  input logic       [wfau_pkg::IO_MANT_W-1:0] r_mant_i,
  input logic        [1:0]                    order_i,
  input wfau_pkg::status_e                    status_i
);
  import wfau_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(r_mant_i))
    else $error("output beat dropped or changed while stalled");

  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while pipeline is held");

  a_mant_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (r_mant_i != '0) |->
      r_mant_i[MANT_BITS-1] && ((r_mant_i >> MANT_BITS) == '0))
    else $error("result mantissa not normalized");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_OK || order_i != ORD_EQ || r_mant_i == '0) |->
      r_mant_i == '0 && !r_sign_i && r_exp_i == '0)
    else $error("zero, compare or error result carries nonzero fields");

endmodule

bind wide_float_arith_unit_top wfau_checker #(.MANT_BITS(MANT_BITS)) u_wfau_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .r_sign_i    (r_sign_o),
  .r_exp_i     (r_exp_o),
  .r_mant_i    (r_mant_o),
  .order_i     (order_o),
  .status_i    (status_o)
);

`default_nettype wire
